FILE: rtl/co2bc_pkg.sv
// Shared types and constants for the CO2 band controller.
`default_nettype none

package co2bc_pkg;

  // Fixed field widths
  localparam int unsigned PpmWidth   = 16;
  localparam int unsigned SpWidth    = 11;
  localparam int unsigned BandWidth  = 9;
  localparam int unsigned FanWidth   = 10;
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Scaling divide: numerator is (co2 - sp) * (max - min)
  localparam int unsigned NumWidth   = PpmWidth + FanWidth;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] RegSetpoint  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegBand      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegHighLimit = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegFanMin    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegFanMax    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegInject    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegWait      = 3'd6;

  // Register reset values
  localparam logic [SpWidth-1:0]   SetpointRst  = 11'd800;
  localparam logic [BandWidth-1:0] BandRst      = 9'd50;
  localparam logic [PpmWidth-1:0]  HighLimitRst = 16'd2000;
  localparam logic [FanWidth-1:0]  FanMinRst    = 10'd300;
  localparam logic [FanWidth-1:0]  FanMaxRst    = 10'd1000;
  localparam logic [TickWidth-1:0] InjectRst    = 16'd1500;
  localparam logic [TickWidth-1:0] WaitRst      = 16'd30000;

  // Action codes
  localparam logic ActTick   = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef struct packed {
    logic                action;
    logic [PpmWidth-1:0] co2_ppm;
  } in_t;

  typedef struct packed {
    logic                valve_open;
    logic [FanWidth-1:0] fan_level;
    logic                fan_on;
    logic                alarm_high;
    logic                is_waiting;
    logic                sample_taken;
  } out_t;

  typedef struct packed {
    logic [SpWidth-1:0]   setpoint_ppm;
    logic [BandWidth-1:0] band_ppm;
    logic [PpmWidth-1:0]  high_limit_ppm;
    logic [FanWidth-1:0]  fan_min;
    logic [FanWidth-1:0]  fan_max;
    logic [TickWidth-1:0] inject_ticks;
    logic [TickWidth-1:0] wait_ticks;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/co2bc_cfg.sv
// Configuration register file for the CO2 band controller.
`default_nettype none

module co2bc_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [co2bc_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [co2bc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output co2bc_pkg::cfg_t                           cfg_o
);

  co2bc_pkg::cfg_t cfg_q, cfg_d;

  // Always take writes
  assign cfg_ready_o = 1'b1;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        co2bc_pkg::RegSetpoint:
          cfg_d.setpoint_ppm = cfg_data_i[co2bc_pkg::SpWidth-1:0];
        co2bc_pkg::RegBand:
          cfg_d.band_ppm = cfg_data_i[co2bc_pkg::BandWidth-1:0];
        co2bc_pkg::RegHighLimit:
          cfg_d.high_limit_ppm = cfg_data_i[co2bc_pkg::PpmWidth-1:0];
        co2bc_pkg::RegFanMin:
          cfg_d.fan_min = cfg_data_i[co2bc_pkg::FanWidth-1:0];
        co2bc_pkg::RegFanMax:
          cfg_d.fan_max = cfg_data_i[co2bc_pkg::FanWidth-1:0];
        co2bc_pkg::RegInject:
          cfg_d.inject_ticks = cfg_data_i[co2bc_pkg::TickWidth-1:0];
        co2bc_pkg::RegWait:
          cfg_d.wait_ticks = cfg_data_i[co2bc_pkg::TickWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_ppm   <= co2bc_pkg::SetpointRst;
      cfg_q.band_ppm       <= co2bc_pkg::BandRst;
      cfg_q.high_limit_ppm <= co2bc_pkg::HighLimitRst;
      cfg_q.fan_min        <= co2bc_pkg::FanMinRst;
      cfg_q.fan_max        <= co2bc_pkg::FanMaxRst;
      cfg_q.inject_ticks   <= co2bc_pkg::InjectRst;
      cfg_q.wait_ticks     <= co2bc_pkg::WaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/co2bc_div.sv
// Restoring divider for the fan scaling, one quotient bit per cycle.
`default_nettype none

module co2bc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [co2bc_pkg::NumWidth-1:0]      num_i,
  input  wire logic [co2bc_pkg::PpmWidth-1:0]      den_i,
  output logic                                     done_o,
  output logic [co2bc_pkg::FanWidth-1:0]           quot_o
);

  // Quotient is known to stay below 2**FanWidth, so only FanWidth steps run
  localparam int unsigned QW = co2bc_pkg::FanWidth;
  localparam int unsigned RW = co2bc_pkg::PpmWidth;
  localparam int unsigned CntWidth = $clog2(QW + 1);

  logic [RW-1:0]       rem_q, rem_d;
  logic [QW-1:0]       sh_q, sh_d;
  logic [RW-1:0]       den_q, den_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [RW:0]         trial;
  logic [RW:0]         diff;

  // Shared subtract-and-compare step
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    diff  = trial - {1'b0, den_q};
  end

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // Load the high part as the first partial remainder
      rem_d  = num_i[co2bc_pkg::NumWidth-1:QW];
      sh_d   = num_i[QW-1:0];
      den_d  = den_i;
      cnt_d  = CntWidth'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Advance one quotient bit
      if (!diff[RW]) begin
        rem_d = diff[RW-1:0];
        sh_d  = {sh_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        sh_d  = {sh_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

FILE: rtl/co2bc_ctrl.sv
// Sequencer and controller state for the CO2 band controller.
`default_nettype none

module co2bc_ctrl #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned PPM_WIDTH   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire co2bc_pkg::cfg_t    cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire co2bc_pkg::in_t     in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output co2bc_pkg::out_t         out_data_o
);

  localparam int unsigned PW = co2bc_pkg::PpmWidth;
  localparam int unsigned FW = co2bc_pkg::FanWidth;
  localparam int unsigned NW = co2bc_pkg::NumWidth;
  localparam int unsigned CoBits = (PPM_WIDTH < PW) ? PPM_WIDTH : PW;
  localparam int unsigned TickBits =
    (COUNT_WIDTH < co2bc_pkg::TickWidth) ? COUNT_WIDTH : co2bc_pkg::TickWidth;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_INJECT = 3'b010,
    PH_WAIT   = 3'b100
  } phase_e;

  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [FW-1:0]          fan_q, fan_d;
  logic                   vent_q, vent_d;
  logic                   alarm_q, alarm_d;
  logic                   taken_q, taken_d;
  logic [PW-1:0]          excess_q, excess_d;
  logic [FW-1:0]          span_q, span_d;
  logic [PW-1:0]          den_q, den_d;
  logic                   out_valid_q, out_valid_d;
  co2bc_pkg::out_t        out_q, out_d;

  logic [PW-1:0]          co2;
  logic [PW:0]            co2_ext, sp_ext, band_ext, lim_ext;
  logic                   is_low, is_high, over_lim, lim_le_sp;
  logic [COUNT_WIDTH-1:0] inject_n, wait_n;
  logic                   count_last;
  logic                   accept;
  logic                   out_free;
  logic                   div_start, div_done;
  logic [NW-1:0]          prod;
  logic [FW-1:0]          quot;

  // Sample compares, all unsigned on one extra bit
  always_comb begin
    co2       = PW'(in_data_i.co2_ppm[CoBits-1:0]);
    co2_ext   = {1'b0, co2};
    sp_ext    = (PW + 1)'(cfg_i.setpoint_ppm);
    band_ext  = (PW + 1)'(cfg_i.band_ppm);
    lim_ext   = {1'b0, cfg_i.high_limit_ppm};
    is_low    = (co2_ext + band_ext) < sp_ext;
    is_high   = co2_ext > (sp_ext + band_ext);
    over_lim  = co2_ext > lim_ext;
    lim_le_sp = lim_ext <= sp_ext;
  end

  // Tick counts masked to the counter width
  assign inject_n   = COUNT_WIDTH'(cfg_i.inject_ticks[TickBits-1:0]);
  assign wait_n     = COUNT_WIDTH'(cfg_i.wait_ticks[TickBits-1:0]);
  assign count_last = (count_q[COUNT_WIDTH-1:1] == '0);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Scaling product, registered inside the divider
  assign prod      = NW'(excess_q) * NW'(span_q);
  assign div_start = (state_q == ST_MUL);

  co2bc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Sequencer and controller update
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    count_d  = count_q;
    fan_d    = fan_q;
    vent_d   = vent_q;
    alarm_d  = alarm_q;
    taken_d  = taken_q;
    excess_d = excess_q;
    span_d   = span_q;
    den_d    = den_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_OUT;
          taken_d = 1'b0;
          if (in_data_i.action == co2bc_pkg::ActTick) begin
            // Count down the injection or the wait
            if (phase_q == PH_INJECT) begin
              if (count_last) begin
                if (wait_n == '0) begin
                  phase_d = PH_IDLE;
                  count_d = '0;
                end else begin
                  phase_d = PH_WAIT;
                  count_d = wait_n;
                end
              end else begin
                count_d = count_q - 1'b1;
              end
            end else if (phase_q == PH_WAIT) begin
              if (count_last) begin
                phase_d = PH_IDLE;
                count_d = '0;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
          end else if (phase_q == PH_IDLE) begin
            taken_d = 1'b1;
            if (is_low) begin
              // Start injection, fan off
              fan_d   = '0;
              vent_d  = 1'b0;
              phase_d = PH_INJECT;
              count_d = (inject_n == '0) ? COUNT_WIDTH'(1) : inject_n;
            end else if (is_high) begin
              vent_d = 1'b1;
              if (over_lim) begin
                alarm_d = 1'b1;
                fan_d   = cfg_i.fan_max;
              end else begin
                alarm_d = 1'b0;
                if (lim_le_sp) begin
                  fan_d = cfg_i.fan_max;
                end else if (cfg_i.fan_max < cfg_i.fan_min) begin
                  // Clamp order settles on the minimum
                  fan_d = cfg_i.fan_min;
                end else begin
                  excess_d = co2 - PW'(cfg_i.setpoint_ppm);
                  span_d   = cfg_i.fan_max - cfg_i.fan_min;
                  den_d    = cfg_i.high_limit_ppm - PW'(cfg_i.setpoint_ppm);
                  state_d  = ST_MUL;
                end
              end
            end else begin
              fan_d  = '0;
              vent_d = 1'b0;
            end
          end
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          fan_d   = cfg_i.fan_min + quot;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: hold while stalled, load when free
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if ((state_q == ST_OUT) && out_free) begin
      out_valid_d        = 1'b1;
      out_d.valve_open   = (phase_q == PH_INJECT);
      out_d.fan_level    = fan_q;
      out_d.fan_on       = vent_q;
      out_d.alarm_high   = alarm_q;
      out_d.is_waiting   = (phase_q == PH_WAIT);
      out_d.sample_taken = taken_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      fan_q       <= '0;
      vent_q      <= 1'b0;
      alarm_q     <= 1'b0;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      fan_q       <= fan_d;
      vent_q      <= vent_d;
      alarm_q     <= alarm_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    excess_q <= excess_d;
    span_q   <= span_d;
    den_q    <= den_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/co2_band_controller_core.sv
// A tick, an ignored sample or an unscaled sample goes from accept to the output state and
// then the output register; a sample on the proportional fan slope passes the multiply
// state, 10 divider steps, the load of the fan level and the output register.
// Items are taken one at a time; the next item is taken the cycle after the result
// enters the output register, and output stalls hold the result back.
// Reset (rst_ni low, asynchronous) restores the default registers and clears state.
`default_nettype none

module co2_band_controller_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned PPM_WIDTH   = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire co2bc_pkg::in_t                     in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output co2bc_pkg::out_t                         out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [co2bc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [co2bc_pkg::CfgDataWidth-1:0] cfg_data_i
);

  co2bc_pkg::cfg_t cfg;

  co2bc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  co2bc_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PPM_WIDTH   (PPM_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
